>>> src/rme_pkg.sv
// rme_pkg: opcodes, fixed field widths and controller/datapath interface types
// for the register machine execute core. No dependencies.
package rme_pkg;

  // fixed field widths of the instruction and result ports
  localparam int unsigned FUNC_W = 4;
  localparam int unsigned OPA_W  = 10;
  localparam int unsigned OPB_W  = 16;
  localparam int unsigned PC_W   = 10;
  localparam int unsigned WV_W   = 32;

  // largest legal jump target
  localparam logic [63:0] PC_MAX = 64'd1023;

  // instruction opcodes
  typedef enum logic [FUNC_W-1:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_STORE = 4'd4,
    OP_LOAD  = 4'd5,
    OP_AFC   = 4'd6,
    OP_EQU   = 4'd7,
    OP_INF   = 4'd8,
    OP_INFE  = 4'd9,
    OP_SUP   = 4'd10,
    OP_SUPE  = 4'd11,
    OP_JMP   = 4'd12,
    OP_JMPZ  = 4'd13
  } op_e;

  // controller to datapath commands
  typedef struct packed {
    logic ready;   // idle, an input transfer may happen
    logic accept;  // input transfer this cycle
    logic exec;    // decode and evaluate the captured instruction
    logic commit;  // write back and load the output register
    logic clear;   // clear one data memory word
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic use_unit;    // instruction needs the iterative mul/div unit
    logic unit_done;   // mul/div result is ready
    logic out_free;    // output register can take a result this cycle
    logic clear_last;  // last memory word is being cleared
  } status_t;

endpackage

>>> src/rme_muldiv.sv
// rme_muldiv: shared iterative unit, one bit per cycle, for wrapping multiply
// and truncating signed divide. Depends on nothing but its parameter.
module rme_muldiv #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  is_div_i,
  input  logic [DATA_WIDTH-1:0] x_i,
  input  logic [DATA_WIDTH-1:0] y_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] result_o
);

  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  div_q;
  logic                  neg_q;
  logic                  zero_q;
  logic [DATA_WIDTH-1:0] x_q;
  logic [DATA_WIDTH-1:0] y_q;
  logic [DATA_WIDTH-1:0] acc_q;
  logic [DATA_WIDTH-1:0] x_mag;
  logic [DATA_WIDTH-1:0] y_mag;
  logic [DATA_WIDTH-1:0] shifted;
  logic                  ge;

  // operand magnitudes for the divide
  assign x_mag = x_i[DATA_WIDTH-1] ? (~x_i + 1'b1) : x_i;
  assign y_mag = y_i[DATA_WIDTH-1] ? (~y_i + 1'b1) : y_i;

  // restoring divide step: remainder stays below the divisor, so the top bit drops
  assign shifted = {acc_q[DATA_WIDTH-2:0], x_q[DATA_WIDTH-1]};
  assign ge      = shifted >= y_q;

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DATA_WIDTH - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift-add multiply or shift-subtract divide datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q  <= is_div_i;
      neg_q  <= x_i[DATA_WIDTH-1] ^ y_i[DATA_WIDTH-1];
      zero_q <= (y_i == '0);
      x_q    <= is_div_i ? x_mag : x_i;
      y_q    <= is_div_i ? y_mag : y_i;
      acc_q  <= '0;
    end else if (busy_q) begin
      if (div_q) begin
        acc_q <= ge ? (shifted - y_q) : shifted;
        x_q   <= {x_q[DATA_WIDTH-2:0], ge};
      end else begin
        if (y_q[0]) begin
          acc_q <= acc_q + x_q;
        end
        x_q <= {x_q[DATA_WIDTH-2:0], 1'b0};
        y_q <= {1'b0, y_q[DATA_WIDTH-1:1]};
      end
    end
  end

  // final sign fix and divide by zero
  always_comb begin
    if (!div_q) begin
      result_o = acc_q;
    end else if (zero_q) begin
      result_o = '0;
    end else if (neg_q) begin
      result_o = ~x_q + 1'b1;
    end else begin
      result_o = x_q;
    end
  end

  assign done_o = done_q;

endmodule

>>> src/rme_datapath.sv
// rme_datapath: register file, data memory, instruction decode, output register.
// Depends on rme_pkg and rme_muldiv.
module rme_datapath #(
  parameter int unsigned NUM_REGS   = 12,
  parameter int unsigned MEM_DEPTH  = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rme_pkg::cmd_t                   cmd_i,
  output rme_pkg::status_t                status_o,
  input  logic [rme_pkg::FUNC_W-1:0]      func_i,
  input  logic [rme_pkg::OPA_W-1:0]       operand_a_i,
  input  logic signed [rme_pkg::OPB_W-1:0] operand_b_i,
  input  logic [rme_pkg::PC_W-1:0]        pc_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rme_pkg::PC_W-1:0]        next_pc_o,
  output logic signed [rme_pkg::WV_W-1:0] write_value_o,
  output logic                            fault_o
);

  localparam int unsigned RIDX_W = $clog2(NUM_REGS);
  localparam int unsigned MA_W   = $clog2(MEM_DEPTH);
  localparam int unsigned RANGE_W = 17;

  // captured instruction
  rme_pkg::op_e                     op_q;
  logic [rme_pkg::OPA_W-1:0]        opa_q;
  logic signed [rme_pkg::OPB_W-1:0] opb_q;
  logic [rme_pkg::PC_W-1:0]         pc_q;

  // storage
  logic [DATA_WIDTH-1:0] rf [NUM_REGS];
  logic [NUM_REGS-1:0]   rf_vld_q;
  logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
  logic [MA_W-1:0]       clr_q;

  // read data
  logic [DATA_WIDTH-1:0] ra_q;
  logic [DATA_WIDTH-1:0] rb_q;
  logic [DATA_WIDTH-1:0] mem_rd_q;

  // read addresses taken straight from the input transfer
  logic [RIDX_W-1:0] ra_idx;
  logic [RIDX_W-1:0] rb_idx;
  logic              ra_in;
  logic              rb_in;
  logic [MA_W-1:0]   mem_raddr;

  // decode results
  logic                  a_reg;
  logic                  b_reg;
  logic                  a_mem;
  logic                  b_mem;
  logic [63:0]           tgt;
  logic [DATA_WIDTH-1:0] res_d;
  logic                  fault_d;
  logic                  rf_we_d;
  logic                  mem_we_d;
  logic                  unit_d;
  logic                  div_d;
  logic [rme_pkg::PC_W-1:0] next_d;

  logic [DATA_WIDTH-1:0]    res_q;
  logic                     fault_q;
  logic                     rf_we_q;
  logic                     mem_we_q;
  logic                     unit_q;
  logic [rme_pkg::PC_W-1:0] next_q;

  // final result and write ports
  logic [DATA_WIDTH-1:0] unit_res;
  logic                  unit_done;
  logic [DATA_WIDTH-1:0] fin;
  logic [RIDX_W-1:0]     rf_waddr;
  logic                  mem_we;
  logic [MA_W-1:0]       mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;

  logic                            out_valid_q;
  logic [rme_pkg::PC_W-1:0]        out_next_q;
  logic signed [rme_pkg::WV_W-1:0] out_wv_q;
  logic                            out_fault_q;

  assign ra_idx    = RIDX_W'(operand_a_i);
  assign rb_idx    = RIDX_W'(operand_b_i[rme_pkg::OPB_W-2:0]);
  assign ra_in     = operand_a_i < rme_pkg::OPA_W'(NUM_REGS);
  assign rb_in     = !operand_b_i[rme_pkg::OPB_W-1] &&
                     (operand_b_i[rme_pkg::OPB_W-2:0] < (rme_pkg::OPB_W-1)'(NUM_REGS));
  assign mem_raddr = MA_W'($unsigned(operand_b_i));

  // capture the instruction on an input transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= rme_pkg::op_e'(func_i);
      opa_q <= operand_a_i;
      opb_q <= operand_b_i;
      pc_q  <= pc_i;
    end
  end

  // register file: registered reads at transfer, write at commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ra_q <= (ra_in && rf_vld_q[ra_idx]) ? rf[ra_idx] : '0;
      rb_q <= (rb_in && rf_vld_q[rb_idx]) ? rf[rb_idx] : '0;
    end
    if (cmd_i.commit && rf_we_q) begin
      rf[rf_waddr] <= fin;
    end
  end

  // an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (cmd_i.commit && rf_we_q) begin
      rf_vld_q[rf_waddr] <= 1'b1;
    end
  end

  // clearing pass address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // data memory: one write port shared by the clearing pass and stores
  assign mem_we    = cmd_i.clear || (cmd_i.commit && mem_we_q);
  assign mem_waddr = cmd_i.clear ? clr_q : MA_W'(opa_q);
  assign mem_wdata = cmd_i.clear ? '0 : res_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.accept) begin
      mem_rd_q <= mem[mem_raddr];
    end
  end

  // range checks on the captured operands
  assign a_reg = opa_q < rme_pkg::OPA_W'(NUM_REGS);
  assign b_reg = !opb_q[rme_pkg::OPB_W-1] &&
                 (opb_q[rme_pkg::OPB_W-2:0] < (rme_pkg::OPB_W-1)'(NUM_REGS));
  assign a_mem = RANGE_W'(opa_q) < RANGE_W'(MEM_DEPTH);
  assign b_mem = !opb_q[rme_pkg::OPB_W-1] &&
                 (RANGE_W'(opb_q[rme_pkg::OPB_W-2:0]) < RANGE_W'(MEM_DEPTH));
  assign tgt   = 64'(ra_q);

  // instruction decode and combinational evaluation; multiply and divide go to the mul/div unit
  always_comb begin
    res_d    = '0;
    fault_d  = 1'b0;
    rf_we_d  = 1'b0;
    mem_we_d = 1'b0;
    unit_d   = 1'b0;
    div_d    = 1'b0;
    next_d   = pc_q + 1'b1;
    unique case (op_q) inside
      rme_pkg::OP_ADD, rme_pkg::OP_SUB, rme_pkg::OP_MUL, rme_pkg::OP_DIV,
      rme_pkg::OP_EQU, rme_pkg::OP_INF, rme_pkg::OP_INFE, rme_pkg::OP_SUP,
      rme_pkg::OP_SUPE: begin
        if (!a_reg || !b_reg) begin
          fault_d = 1'b1;
        end else begin
          rf_we_d = 1'b1;
          case (op_q)
            rme_pkg::OP_ADD:  res_d = ra_q + rb_q;
            rme_pkg::OP_SUB:  res_d = ra_q - rb_q;
            rme_pkg::OP_MUL:  unit_d = 1'b1;
            rme_pkg::OP_DIV: begin
              unit_d = 1'b1;
              div_d  = 1'b1;
            end
            rme_pkg::OP_EQU:  res_d = DATA_WIDTH'(ra_q == rb_q);
            rme_pkg::OP_INF:  res_d = DATA_WIDTH'($signed(ra_q) < $signed(rb_q));
            rme_pkg::OP_INFE: res_d = DATA_WIDTH'($signed(ra_q) <= $signed(rb_q));
            rme_pkg::OP_SUP:  res_d = DATA_WIDTH'($signed(ra_q) > $signed(rb_q));
            default:          res_d = DATA_WIDTH'($signed(ra_q) >= $signed(rb_q));
          endcase
        end
      end
      rme_pkg::OP_STORE: begin
        if (!a_mem || !b_reg) begin
          fault_d = 1'b1;
        end else begin
          mem_we_d = 1'b1;
          res_d    = rb_q;
        end
      end
      rme_pkg::OP_LOAD: begin
        if (!a_reg || !b_mem) begin
          fault_d = 1'b1;
        end else begin
          rf_we_d = 1'b1;
          res_d   = mem_rd_q;
        end
      end
      rme_pkg::OP_AFC: begin
        if (!a_reg) begin
          fault_d = 1'b1;
        end else begin
          rf_we_d = 1'b1;
          res_d   = DATA_WIDTH'(opb_q);
        end
      end
      rme_pkg::OP_JMP, rme_pkg::OP_JMPZ: begin
        if (!a_reg || (op_q == rme_pkg::OP_JMPZ && !b_reg)) begin
          fault_d = 1'b1;
        end else if (op_q == rme_pkg::OP_JMPZ && rb_q != '0) begin
          // condition false, fall through
          fault_d = 1'b0;
        end else if (ra_q[DATA_WIDTH-1] || tgt > rme_pkg::PC_MAX) begin
          fault_d = 1'b1;
        end else begin
          next_d = tgt[rme_pkg::PC_W-1:0];
        end
      end
      default: begin
        // unused opcodes leave all state alone
        fault_d = 1'b0;
      end
    endcase
  end

  // decode results held until write-back
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_q    <= res_d;
      fault_q  <= fault_d;
      rf_we_q  <= rf_we_d;
      mem_we_q <= mem_we_d;
      unit_q   <= unit_d;
      next_q   <= next_d;
    end
  end

  rme_muldiv #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.exec && unit_d),
    .is_div_i(div_d),
    .x_i     (ra_q),
    .y_i     (rb_q),
    .done_o  (unit_done),
    .result_o(unit_res)
  );

  assign fin      = unit_q ? unit_res : res_q;
  assign rf_waddr = RIDX_W'(opa_q);

  // output register, freed by a transfer on the result side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_next_q  <= next_q;
      out_wv_q    <= rme_pkg::WV_W'($signed(fin));
      out_fault_q <= fault_q;
    end
  end

  // status back to the controller
  assign status_o.use_unit   = unit_d;
  assign status_o.unit_done  = unit_done;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign status_o.clear_last = clr_q == MA_W'(MEM_DEPTH - 1);

  assign out_valid_o   = out_valid_q;
  assign next_pc_o     = out_next_q;
  assign write_value_o = out_wv_q;
  assign fault_o       = out_fault_q;

endmodule

>>> src/rme_ctrl.sv
// rme_ctrl: sequencer for the execute core, drives the datapath commands.
// Depends on rme_pkg.
module rme_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  rme_pkg::status_t status_i,
  output rme_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_ITER,
    ST_WB
  } state_e;

  state_e state_q;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      unique case (state_q)
        ST_CLEAR: if (status_i.clear_last) state_q <= ST_IDLE;
        ST_IDLE:  if (in_valid_i) state_q <= ST_EXEC;
        ST_EXEC:  state_q <= status_i.use_unit ? ST_ITER : ST_WB;
        ST_ITER:  if (status_i.unit_done) state_q <= ST_WB;
        ST_WB:    if (status_i.out_free) state_q <= ST_IDLE;
        default:  state_q <= ST_CLEAR;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd_o        = '0;
    cmd_o.ready  = state_q == ST_IDLE;
    cmd_o.accept = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.exec   = state_q == ST_EXEC;
    cmd_o.commit = (state_q == ST_WB) && status_i.out_free;
    cmd_o.clear  = state_q == ST_CLEAR;
  end

endmodule

>>> src/register_machine_execute_core.sv
// register_machine_execute_core: top level of the load/store machine execute unit.
// Depends on rme_pkg, rme_ctrl and rme_datapath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one instruction per transfer:
//   opcode, two operands and its program index. Output channel (out_valid_o /
//   out_stall_i) carries one result per instruction: next program index, value
//   written and fault flag, in instruction order.
//   Sequence: one instruction at a time. Most instructions go from input
//   transfer to the next possible input transfer through transfer with operand
//   reads, decode and write-back; the result shows on the output in the cycle
//   after write-back. Multiply and divide also run through the bit-serial
//   mul/div unit between decode and write-back.
//   Reset: the register file clears at once; the data memory is cleared by
//   a pass over its MEM_DEPTH words (1024 by default), with in_stall_o high.
//   Stall: a finished result waits in the output register while out_stall_i
//   is high; the next instruction is still taken and executed, and write-back
//   of that one waits until the output register is free.
module register_machine_execute_core #(
  parameter int unsigned NUM_REGS   = 12,
  parameter int unsigned MEM_DEPTH  = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [rme_pkg::FUNC_W-1:0]       func_i,
  input  logic [rme_pkg::OPA_W-1:0]        operand_a_i,
  input  logic signed [rme_pkg::OPB_W-1:0] operand_b_i,
  input  logic [rme_pkg::PC_W-1:0]         pc_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [rme_pkg::PC_W-1:0]         next_pc_o,
  output logic signed [rme_pkg::WV_W-1:0]  write_value_o,
  output logic                             fault_o
);

  rme_pkg::cmd_t    cmd;
  rme_pkg::status_t status;

  rme_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  rme_datapath #(
    .NUM_REGS  (NUM_REGS),
    .MEM_DEPTH (MEM_DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .func_i       (func_i),
    .operand_a_i  (operand_a_i),
    .operand_b_i  (operand_b_i),
    .pc_i         (pc_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .next_pc_o    (next_pc_o),
    .write_value_o(write_value_o),
    .fault_o      (fault_o)
  );

  assign in_stall_o = !cmd.ready;

  // a faulted instruction reports no written value
  a_fault_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_o |-> write_value_o == '0)
    else $error("faulted result carries a nonzero value");

  // one instruction at a time: an input transfer closes the input side
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a transfer");

  // a new result only comes from write-back, never from the idle state
  a_result_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an instruction in flight");

endmodule

>>> tb/sv/register_machine_execute_core_test.sv
// register_machine_execute_core_test: self-checking testbench for the register machine
// execute core, with an instruction driver, a result monitor and its own execute model.
// Depends on rme_pkg and register_machine_execute_core.
module register_machine_execute_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NREGS          = 12;
  localparam int MEM_WORDS      = 1024;
  localparam int DIRECTED_COUNT = 30;
  localparam int ISSUE_TOTAL    = DIRECTED_COUNT + 850;
  localparam int CALM_TAIL      = 80;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_WAIT     = 50;

  // opcodes with no meaning to the core
  localparam logic [rme_pkg::FUNC_W-1:0] OP_SPARE_LO = 4'd14;
  localparam logic [rme_pkg::FUNC_W-1:0] OP_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [rme_pkg::FUNC_W-1:0] func;
    logic [rme_pkg::OPA_W-1:0]  opa;
    logic [rme_pkg::OPB_W-1:0]  opb;
    logic [rme_pkg::PC_W-1:0]   pc;
    logic                       calm;   // no idling on either side from here on
    logic                       drain;  // hold off until every result is back
  } instr_t;

  typedef struct packed {
    logic [rme_pkg::PC_W-1:0] next_pc;
    logic [rme_pkg::WV_W-1:0] write_value;
    logic                     fault;
  } result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  instr_t                          cur_instr = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [rme_pkg::PC_W-1:0]        next_pc;
  logic signed [rme_pkg::WV_W-1:0] write_value;
  logic                            fault;

  // model state of the machine
  logic [rme_pkg::WV_W-1:0] gpr [NREGS];
  logic [rme_pkg::WV_W-1:0] dmem [MEM_WORDS];

  instr_t  instr_queue [$];
  result_t retire_queue [$];
  int      n_issued = 0;
  int      n_retired = 0;
  int      issue_total = 0;
  int      error_count = 0;
  int      gap_left = 0;
  int      stall_left = 0;
  int      quiet_cycles = 0;
  logic    send_busy = 1'b1;
  logic    recv_busy = 1'b1;
  logic    in_calm = 1'b0;

  register_machine_execute_core #(
    .NUM_REGS  (NREGS),
    .MEM_DEPTH (MEM_WORDS),
    .DATA_WIDTH(rme_pkg::WV_W)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .func_i       (cur_instr.func),
    .operand_a_i  (cur_instr.opa),
    .operand_b_i  (cur_instr.opb),
    .pc_i         (cur_instr.pc),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .next_pc_o    (next_pc),
    .write_value_o(write_value),
    .fault_o      (fault)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // execute one instruction against the model state
  function automatic result_t execute_instr(instr_t ins);
    result_t                  res;
    logic [rme_pkg::WV_W-1:0] ra;
    logic [rme_pkg::WV_W-1:0] rb;
    logic [rme_pkg::WV_W-1:0] r;
    logic                     a_ok;
    logic                     b_ok;
    logic                     b_neg;
    logic                     wr_reg;
    ra = '0;
    rb = '0;
    r = '0;
    wr_reg = 1'b0;
    res.next_pc = ins.pc + 10'd1;
    res.write_value = '0;
    res.fault = 1'b0;
    a_ok = ins.opa < NREGS;
    b_neg = ins.opb[rme_pkg::OPB_W-1];
    b_ok = !b_neg && ins.opb < NREGS;
    if (a_ok) ra = gpr[ins.opa];
    if (b_ok) rb = gpr[ins.opb];
    case (ins.func)
      rme_pkg::OP_ADD, rme_pkg::OP_SUB, rme_pkg::OP_MUL, rme_pkg::OP_DIV,
      rme_pkg::OP_EQU, rme_pkg::OP_INF, rme_pkg::OP_INFE, rme_pkg::OP_SUP,
      rme_pkg::OP_SUPE: begin
        if (!a_ok || !b_ok) begin
          res.fault = 1'b1;
        end else begin
          case (ins.func)
            rme_pkg::OP_ADD:  r = ra + rb;
            rme_pkg::OP_SUB:  r = ra - rb;
            rme_pkg::OP_MUL:  r = ra * rb;
            rme_pkg::OP_DIV: begin
              // zero divisor gives zero, most negative over minus one wraps
              if (rb == '0) r = '0;
              else if (ra == 32'h8000_0000 && rb == '1) r = ra;
              else r = $signed(ra) / $signed(rb);
            end
            rme_pkg::OP_EQU:  r = {31'd0, ra == rb};
            rme_pkg::OP_INF:  r = {31'd0, $signed(ra) < $signed(rb)};
            rme_pkg::OP_INFE: r = {31'd0, $signed(ra) <= $signed(rb)};
            rme_pkg::OP_SUP:  r = {31'd0, $signed(ra) > $signed(rb)};
            rme_pkg::OP_SUPE: r = {31'd0, $signed(ra) >= $signed(rb)};
            default: r = '0;
          endcase
          wr_reg = 1'b1;
        end
      end
      rme_pkg::OP_STORE: begin
        if (!b_ok) begin
          res.fault = 1'b1;
        end else begin
          dmem[ins.opa] = rb;
          res.write_value = rb;
        end
      end
      rme_pkg::OP_LOAD: begin
        if (!a_ok || b_neg || ins.opb >= MEM_WORDS) begin
          res.fault = 1'b1;
        end else begin
          r = dmem[ins.opb];
          wr_reg = 1'b1;
        end
      end
      rme_pkg::OP_AFC: begin
        if (!a_ok) begin
          res.fault = 1'b1;
        end else begin
          r = {{16{ins.opb[rme_pkg::OPB_W-1]}}, ins.opb};
          wr_reg = 1'b1;
        end
      end
      rme_pkg::OP_JMP, rme_pkg::OP_JMPZ: begin
        // target comes from register a, checked only when the jump is taken
        if (!a_ok || (ins.func == rme_pkg::OP_JMPZ && !b_ok)) begin
          res.fault = 1'b1;
        end else if (ins.func == rme_pkg::OP_JMP || rb == '0) begin
          if (ra[rme_pkg::WV_W-1] || ra > rme_pkg::PC_MAX[rme_pkg::WV_W-1:0]) res.fault = 1'b1;
          else res.next_pc = ra[rme_pkg::PC_W-1:0];
        end
      end
      default: begin
      end
    endcase
    if (wr_reg) begin
      gpr[ins.opa] = r;
      res.write_value = r;
    end
    return res;
  endfunction

  // stimulus helpers
  task automatic issue(input logic [rme_pkg::FUNC_W-1:0] f,
                       input logic [rme_pkg::OPA_W-1:0] a,
                       input logic [rme_pkg::OPB_W-1:0] b,
                       input logic [rme_pkg::PC_W-1:0] pc);
    instr_t it;
    it.func = f;
    it.opa = a;
    it.opb = b;
    it.pc = pc;
    it.calm = instr_queue.size() >= ISSUE_TOTAL - CALM_TAIL;
    it.drain = instr_queue.size() == 300 || instr_queue.size() == 600;
    instr_queue.push_back(it);
  endtask

  task automatic issue_seq(input logic [rme_pkg::FUNC_W-1:0] f,
                           input logic [rme_pkg::OPA_W-1:0] a,
                           input logic [rme_pkg::OPB_W-1:0] b);
    issue(f, a, b, rme_pkg::PC_W'(instr_queue.size()));
  endtask

  function automatic logic [rme_pkg::PC_W-1:0] rpc();
    return rme_pkg::PC_W'($urandom_range(0, 1023));
  endfunction

  function automatic logic [rme_pkg::OPA_W-1:0] pick_reg();
    if ($urandom_range(0, 19) == 0) return rme_pkg::OPA_W'($urandom_range(NREGS, 1023));
    return rme_pkg::OPA_W'($urandom_range(0, NREGS - 1));
  endfunction

  function automatic logic [rme_pkg::OPB_W-1:0] pick_src();
    case ($urandom_range(0, 23))
      0:       return rme_pkg::OPB_W'($urandom_range(32768, 65535));
      1:       return rme_pkg::OPB_W'($urandom_range(NREGS, 32767));
      default: return rme_pkg::OPB_W'($urandom_range(0, NREGS - 1));
    endcase
  endfunction

  function automatic logic [rme_pkg::OPB_W-1:0] pick_imm();
    case ($urandom_range(0, 3))
      0:       return rme_pkg::OPB_W'($urandom_range(0, 1023));
      1:       return rme_pkg::OPB_W'($urandom);
      2:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      default: return rme_pkg::OPB_W'($urandom_range(0, 31)) - 16'd16;
    endcase
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // driver: issue instructions, predict the result of each input transfer
  always @(posedge clk or negedge rst_n) begin
    instr_t nxt;
    int     took;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      n_issued <= 0;
      foreach (gpr[i]) gpr[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
    end else begin
      took = 0;
      if (in_valid && !in_stall) begin
        retire_queue.push_back(execute_instr(cur_instr));
        took = 1;
        n_issued <= n_issued + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (instr_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (instr_queue[0].drain && n_retired != n_issued + took) begin
          in_valid <= 1'b0;
        end else if (!instr_queue[0].calm && send_busy && $urandom_range(0, 3) == 0) begin
          gap_left <= $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else begin
          nxt = instr_queue.pop_front();
          cur_instr <= nxt;
          in_calm <= nxt.calm;
          in_valid <= 1'b1;
        end
      end
      if ($urandom_range(0, 63) == 0) send_busy <= !send_busy;
    end
  end

  // monitor: check each output transfer against the oldest prediction
  always @(posedge clk or negedge rst_n) begin
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      n_retired <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (n_retired == n_issued) begin
          flag_error($sformatf("unexpected result: next_pc %0d write_value %0d fault %0b",
                               next_pc, write_value, fault));
        end else begin
          want = retire_queue.pop_front();
          n_retired <= n_retired + 1;
          if (next_pc !== want.next_pc || write_value !== want.write_value ||
              fault !== want.fault)
            flag_error($sformatf({"result %0d: next_pc exp %0d got %0d, ",
                                  "write_value exp %0d got %0d, fault exp %0b got %0b"},
                                 n_retired, want.next_pc, next_pc,
                                 $signed(want.write_value), write_value, want.fault, fault));
        end
      end
      // receiver stall bursts
      if (in_calm) begin
        out_stall <= 1'b0;
        stall_left <= 0;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (recv_busy && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 7);
      end else begin
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 63) == 0) recv_busy <= !recv_busy;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // program build, reset and end of run
  initial begin
    logic [rme_pkg::OPA_W-1:0] x;
    logic [rme_pkg::OPA_W-1:0] y;
    logic [rme_pkg::OPA_W-1:0] z;
    logic [rme_pkg::OPA_W-1:0] addr;
    logic [rme_pkg::OPB_W-1:0] t;

    // directed: build the most negative word, then walk every opcode
    issue_seq(rme_pkg::OP_AFC, 10'd1, 16'h8000);
    issue_seq(rme_pkg::OP_AFC, 10'd2, 16'd256);
    issue_seq(rme_pkg::OP_MUL, 10'd1, 16'd2);
    issue_seq(rme_pkg::OP_MUL, 10'd1, 16'd2);
    issue_seq(rme_pkg::OP_AFC, 10'd3, 16'hffff);
    issue_seq(rme_pkg::OP_DIV, 10'd1, 16'd3);         // divide overflow
    issue_seq(rme_pkg::OP_DIV, 10'd2, 16'd4);         // divide by zero
    issue_seq(rme_pkg::OP_AFC, 10'd11, 16'h7fff);
    issue_seq(rme_pkg::OP_ADD, 10'd11, 16'd11);
    issue_seq(rme_pkg::OP_SUB, 10'd0, 16'd11);
    issue_seq(rme_pkg::OP_EQU, 10'd5, 16'd6);
    issue_seq(rme_pkg::OP_INF, 10'd3, 16'd11);
    issue_seq(rme_pkg::OP_INFE, 10'd0, 16'd0);
    issue_seq(rme_pkg::OP_SUP, 10'd11, 16'd3);
    issue_seq(rme_pkg::OP_SUPE, 10'd5, 16'd0);
    issue_seq(rme_pkg::OP_STORE, 10'd1023, 16'd11);
    issue_seq(rme_pkg::OP_LOAD, 10'd7, 16'd1023);
    issue_seq(rme_pkg::OP_LOAD, 10'd8, 16'h7fff);     // address out of range
    issue(rme_pkg::OP_ADD, 10'd1023, 16'd0, 10'd1023); // bad register, pc wraps
    issue_seq(rme_pkg::OP_ADD, 10'd0, 16'hffff);      // negative source index
    issue_seq(rme_pkg::OP_AFC, 10'd9, 16'd1000);
    issue_seq(rme_pkg::OP_JMP, 10'd9, 16'd0);
    issue_seq(rme_pkg::OP_JMPZ, 10'd9, 16'd4);        // taken
    issue_seq(rme_pkg::OP_AFC, 10'd10, 16'hfffb);
    issue_seq(rme_pkg::OP_JMP, 10'd10, 16'd0);        // negative target
    issue_seq(rme_pkg::OP_JMPZ, 10'd10, 16'd9);       // not taken, target unchecked
    issue_seq(rme_pkg::OP_AFC, 10'd10, 16'd1024);
    issue_seq(rme_pkg::OP_JMP, 10'd10, 16'd0);        // target past last pc
    issue(OP_SPARE_LO, rme_pkg::OPA_W'($urandom), rme_pkg::OPB_W'($urandom), rpc());
    issue(OP_SPARE_HI, rme_pkg::OPA_W'($urandom), rme_pkg::OPB_W'($urandom), rpc());

    // random: mostly short well-formed sequences, some noise
    while (instr_queue.size() < ISSUE_TOTAL) begin
      x = pick_reg();
      y = pick_reg();
      z = pick_reg();
      case ($urandom_range(0, 9))
        0, 1: begin
          issue(rme_pkg::OP_AFC, x, pick_imm(), rpc());
          issue(rme_pkg::OP_AFC, y, pick_imm(), rpc());
          issue(4'($urandom_range(rme_pkg::OP_ADD, rme_pkg::OP_DIV)), x,
                rme_pkg::OPB_W'(y), rpc());
          if ($urandom_range(0, 1))
            issue(4'($urandom_range(rme_pkg::OP_ADD, rme_pkg::OP_DIV)), x, pick_src(), rpc());
        end
        2: begin
          t = pick_imm();
          issue(rme_pkg::OP_AFC, x, t, rpc());
          issue(rme_pkg::OP_AFC, y, $urandom_range(0, 2) == 0 ? t : pick_imm(), rpc());
          issue(4'($urandom_range(rme_pkg::OP_EQU, rme_pkg::OP_SUPE)), x,
                rme_pkg::OPB_W'(y), rpc());
        end
        3, 4: begin
          addr = rme_pkg::OPA_W'($urandom_range(0, MEM_WORDS - 1));
          issue(rme_pkg::OP_AFC, x, pick_imm(), rpc());
          issue(rme_pkg::OP_STORE, addr, rme_pkg::OPB_W'(x), rpc());
          if ($urandom_range(0, 7) == 0)
            issue(rme_pkg::OP_LOAD, z, 16'($urandom_range(1024, 65535)), rpc());
          else issue(rme_pkg::OP_LOAD, z, rme_pkg::OPB_W'(addr), rpc());
        end
        5, 6: begin
          t = $urandom_range(0, 4) == 0 ? pick_imm() :
              rme_pkg::OPB_W'($urandom_range(0, 1023));
          issue(rme_pkg::OP_AFC, x, t, rpc());
          if ($urandom_range(0, 1)) begin
            issue(rme_pkg::OP_JMP, x, pick_src(), rpc());
          end else begin
            issue(rme_pkg::OP_AFC, z, $urandom_range(0, 2) == 0 ? pick_imm() : 16'd0, rpc());
            issue(rme_pkg::OP_JMPZ, x, rme_pkg::OPB_W'(z), rpc());
          end
        end
        7: issue(4'($urandom_range(rme_pkg::OP_ADD, OP_SPARE_HI)), rme_pkg::OPA_W'($urandom),
                 rme_pkg::OPB_W'($urandom), rpc());
        default: issue(4'($urandom_range(rme_pkg::OP_ADD, rme_pkg::OP_JMPZ)), pick_reg(),
                       pick_src(), rpc());
      endcase
    end
    issue_total = instr_queue.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (n_retired != issue_total) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && retire_queue.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> register_machine_execute_core.f
src/rme_pkg.sv
src/rme_muldiv.sv
src/rme_datapath.sv
src/rme_ctrl.sv
src/register_machine_execute_core.sv
tb/sv/register_machine_execute_core_test.sv
